@@ rtl/core/dvc_pkg.sv @@
package dvc_pkg;

    // Digit code carried on the result port; the value ten means no digit.
    typedef logic [3:0] t_digit;

    localparam t_digit NO_DIGIT  = 4'd10;
    localparam t_digit DIGIT_ONE = 4'd1;

    // Register indexes as decoded from paddr[2].
    localparam logic REG_VOTE_THR  = 1'b0;
    localparam logic REG_WIDTH_THR = 1'b1;

    localparam logic [7:0]  VOTE_THR_RESET  = 8'd8;
    localparam logic [11:0] WIDTH_THR_RESET = 12'd16;

    localparam logic [17:0] FEATURE_MASK = 18'h3FFCF;

    localparam logic [17:0] PAT_ZERO  = 18'h0888F;
    localparam logic [17:0] PAT_TWO   = 18'h044C6;
    localparam logic [17:0] PAT_SPLIT = 18'h044CA;
    localparam logic [17:0] PAT_FOUR  = 18'h0848E;
    localparam logic [17:0] PAT_FIVE  = 18'h044C9;
    localparam logic [17:0] PAT_FIVEB = 18'h04449;
    localparam logic [17:0] PAT_SIX   = 18'h084CD;
    localparam logic [17:0] PAT_SEVEN = 18'h0448A;
    localparam logic [17:0] PAT_EIGHT = 18'h088CF;
    localparam logic [17:0] PAT_NINE  = 18'h048CB;

    // Match a feature word against the digit table. The split pattern is
    // resolved by bits 5 and 4 of the unmasked word.
    function automatic t_digit classify(input logic [17:0] word);
        logic [17:0] masked;
        t_digit      code;
        masked = word & FEATURE_MASK;
        case (masked)
            PAT_ZERO:  code = 4'd0;
            PAT_TWO:   code = 4'd2;
            PAT_SPLIT: begin
                if (word[5]) begin
                    code = 4'd7;
                end else if (word[4]) begin
                    code = 4'd3;
                end else begin
                    code = NO_DIGIT;
                end
            end
            PAT_FOUR:  code = 4'd4;
            PAT_FIVE:  code = 4'd5;
            PAT_FIVEB: code = 4'd5;
            PAT_SIX:   code = 4'd6;
            PAT_SEVEN: code = 4'd7;
            PAT_EIGHT: code = 4'd8;
            PAT_NINE:  code = 4'd9;
            default:   code = NO_DIGIT;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/core/digit_vote_classifier_unit.sv @@
// A word taken into stage 1 has its digit, if it causes one, written into the output
// register when stage 1 advances; a word that causes no digit leaves nothing behind.
// Throughput: one word per cycle, set by the single read and write port of the counter RAM.
// Input stalls only while a firing word waits for a full output register, and while
// the counters are re-read after vote_threshold is written.
// Reset: thresholds return to 8 and 16 and all counters read as zero at once (no clearing pass).
module digit_vote_classifier_unit #(
    parameter int NUM_DIGITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [17:0] i_feature_word,
    input  logic [11:0] i_left_edge,
    input  logic [11:0] i_right_edge,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_digit,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(NUM_DIGITS);

    // ------------------------------------------------------------------
    // Configuration registers. Only paddr[2] selects a register, so every
    // address lands on one of the two.
    // ------------------------------------------------------------------
    logic [7:0]  r_vote_thr;
    logic [11:0] r_width_thr;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vote_thr  <= dvc_pkg::VOTE_THR_RESET;
            r_width_thr <= dvc_pkg::WIDTH_THR_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == dvc_pkg::REG_VOTE_THR) begin
                r_vote_thr <= pwdata[7:0];
            end else begin
                r_width_thr <= pwdata[11:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == dvc_pkg::REG_WIDTH_THR) begin
            prdata = {20'd0, r_width_thr};
        end else begin
            prdata = {24'd0, r_vote_thr};
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: the edge test and the table lookup happen as the word is
    // taken, and the counter of the voted digit is read from the RAM.
    // A narrow character always votes for digit one. A reversed pair of
    // edges counts as wide by its own test, whatever the wrapped width.
    // ------------------------------------------------------------------
    logic [11:0]        s0_width;
    logic               s0_wide;
    dvc_pkg::t_digit    s0_code;
    dvc_pkg::t_digit    s0_digit;
    logic               s0_vote;
    logic [IDX_W-1:0]   s0_addr;
    logic               in_acc;

    always_comb begin
        s0_width = i_right_edge - i_left_edge;
        s0_wide  = (i_right_edge < i_left_edge) || (s0_width > r_width_thr);
        s0_code  = dvc_pkg::classify(i_feature_word);
        if (s0_wide) begin
            s0_digit = s0_code;
            s0_vote  = (s0_code != dvc_pkg::NO_DIGIT);
        end else begin
            s0_digit = dvc_pkg::DIGIT_ONE;
            s0_vote  = 1'b1;
        end
        s0_addr = s0_vote ? IDX_W'(s0_digit) : '0;
    end

    // ------------------------------------------------------------------
    // Stage 1 registers and the state around the counter RAM.
    // r_cnt_valid marks counters that have been written since the last
    // clear; an entry without its mark reads as zero, which is how reset
    // and a firing digit clear all counters at once.
    // r_match holds, for every digit, whether its counter equals the vote
    // threshold. A word that does not fire changes it at most at one place,
    // so the scan over all digits reduces to an OR and a priority pick.
    // r_wr_* keeps the last RAM write so that a word read at the edge of
    // that write still sees the new count.
    // ------------------------------------------------------------------
    logic                  r_s1_valid;
    logic                  r_s1_vote;
    logic [IDX_W-1:0]      r_s1_addr;
    logic [NUM_DIGITS-1:0] r_cnt_valid;
    logic [NUM_DIGITS-1:0] r_match;
    logic                  r_wr_valid;
    logic [IDX_W-1:0]      r_wr_addr;
    logic [7:0]            r_wr_data;
    logic                  r_o_valid;
    dvc_pkg::t_digit       r_o_digit;

    // Threshold re-read after a vote_threshold write.
    logic                  r_sw_on;
    logic [IDX_W-1:0]      r_sw_idx;
    logic                  r_sw_pend;
    logic [IDX_W-1:0]      r_sw_cmp_idx;
    logic                  sw_busy;
    logic                  sw_issue;

    logic [7:0]            ram_rdata;
    logic                  ram_we;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;

    logic [7:0]            s1_cnt_raw;
    logic [7:0]            s1_cnt;
    logic [7:0]            s1_cnt_new;
    logic [NUM_DIGITS-1:0] s1_match;
    logic                  s1_fire;
    logic [IDX_W-1:0]      s1_fire_idx;
    logic                  s1_go;
    logic                  s1_adv;
    logic                  out_free;
    logic [7:0]            sw_cnt;

    assign sw_busy  = r_sw_on || r_sw_pend;
    assign sw_issue = r_sw_on;

    always_comb begin
        s1_cnt_raw = (r_wr_valid && (r_wr_addr == r_s1_addr)) ? r_wr_data : ram_rdata;
        s1_cnt     = r_cnt_valid[r_s1_addr] ? s1_cnt_raw : 8'd0;
        s1_cnt_new = s1_cnt + 8'd1;
        s1_match   = r_match;
        if (r_s1_vote) begin
            s1_match[r_s1_addr] = (s1_cnt_new == r_vote_thr);
        end
        s1_fire     = |s1_match;
        // Lowest set digit wins, as in a scan from digit zero upward.
        s1_fire_idx = '0;
        for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
            if (s1_match[k]) begin
                s1_fire_idx = IDX_W'(k);
            end
        end
    end

    assign out_free = !r_o_valid || i_ready;
    assign s1_go    = !s1_fire || out_free;
    assign s1_adv   = r_s1_valid && s1_go;
    assign o_ready  = !sw_busy && (!r_s1_valid || s1_go);
    assign in_acc   = i_valid && o_ready;

    assign ram_we    = s1_adv && r_s1_vote;
    assign ram_re    = in_acc || sw_issue;
    assign ram_raddr = sw_issue ? r_sw_idx : s0_addr;

    dvc_ram #(
        .WIDTH (8),
        .DEPTH (NUM_DIGITS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_addr),
        .i_wdata (s1_cnt_new),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Stage 1 holds its word while a firing result waits for the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_vote <= s0_vote;
            r_s1_addr <= s0_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_valid <= 1'b0;
        end else if (ram_we) begin
            r_wr_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_wr_addr <= r_s1_addr;
            r_wr_data <= s1_cnt_new;
        end
    end

    // The re-read compares each stored counter with the new threshold.
    assign sw_cnt = r_cnt_valid[r_sw_cmp_idx] ? ram_rdata : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_valid <= '0;
            r_match     <= '0;
        end else if (s1_adv) begin
            if (s1_fire) begin
                r_cnt_valid <= '0;
                r_match     <= {NUM_DIGITS{r_vote_thr == 8'd0}};
            end else begin
                if (r_s1_vote) begin
                    r_cnt_valid[r_s1_addr] <= 1'b1;
                end
                r_match <= s1_match;
            end
        end else if (r_sw_pend) begin
            r_match[r_sw_cmp_idx] <= (sw_cnt == r_vote_thr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_on   <= 1'b0;
            r_sw_idx  <= '0;
            r_sw_pend <= 1'b0;
        end else begin
            r_sw_pend <= sw_issue;
            if (cfg_wr && (paddr[2] == dvc_pkg::REG_VOTE_THR)) begin
                r_sw_on  <= 1'b1;
                r_sw_idx <= '0;
            end else if (sw_issue) begin
                if (r_sw_idx == IDX_W'(NUM_DIGITS - 1)) begin
                    r_sw_on <= 1'b0;
                end
                r_sw_idx <= r_sw_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sw_issue) begin
            r_sw_cmp_idx <= r_sw_idx;
        end
    end

    // ------------------------------------------------------------------
    // Output register: parts the result side from the counter pipeline.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv && s1_fire) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_fire) begin
            r_o_digit <= 4'(s1_fire_idx);
        end
    end

    assign o_valid = r_o_valid;
    assign o_digit = r_o_digit;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A firing digit leaves every counter cleared and a uniform match vector.
    a_fire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && s1_fire) |=> ((r_cnt_valid == '0)
                                 && ((r_match == '0) || (&r_match))))
        else $error("fire did not clear the vote counters");

    // No word is taken in the cycle after the vote threshold changes.
    a_sweep_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && (paddr[2] == dvc_pkg::REG_VOTE_THR)) |=> !o_ready)
        else $error("word accepted during threshold re-read");

    // A delivered digit is always a real decimal digit.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit < 4'(NUM_DIGITS)))
        else $error("digit out of range");

    // A result waiting in the output register is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_ready) |=> (r_o_valid && $stable(r_o_digit)))
        else $error("pending digit overwritten");

endmodule

@@ rtl/core/dvc_ram.sv @@
module dvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when the same entry is written at that edge.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
